@@ hw/rtl/su3r_pkg.sv @@
// Package for the SU(3) third-row reconstruction block.
// Holds the value format, item and control types and the cross-product term table.
// No dependencies.
`default_nettype none

package su3r_pkg;

  // value format: two's complement, two integer bits
  localparam int VALUE_BITS   = 32;
  localparam int FRAC_BITS    = VALUE_BITS - 2;
  localparam int PROD_W       = 2 * VALUE_BITS;
  localparam int ACC_W        = PROD_W + 2;

  localparam int PASS_COUNT   = 12;
  localparam int MATRIX_COUNT = 18;
  localparam int LANE_COUNT   = MATRIX_COUNT - PASS_COUNT;
  localparam int TERM_COUNT   = 4;
  localparam int POS_W        = 5;
  localparam int IDX_W        = $clog2(PASS_COUNT);
  localparam int LANE_W       = $clog2(LANE_COUNT);
  localparam int TERM_W       = $clog2(TERM_COUNT);

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MATRIX_COUNT - 1);

  // round to nearest, halves upwards
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

  // lane sequencing steps
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_LAST_MUL = 3'd3;
  localparam logic [STEP_W-1:0] STEP_ACC_LOAD = 3'd1;
  localparam logic [STEP_W-1:0] STEP_LAST_ACC = 3'd4;
  localparam logic [STEP_W-1:0] STEP_FIN      = 3'd5;
  localparam logic [STEP_W-1:0] STEP_DONE     = 3'd6;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] row_one_col_zero_re;
    logic signed [VALUE_BITS-1:0] row_one_col_zero_im;
    logic signed [VALUE_BITS-1:0] row_one_col_one_re;
    logic signed [VALUE_BITS-1:0] row_one_col_one_im;
    logic signed [VALUE_BITS-1:0] row_one_col_two_re;
    logic signed [VALUE_BITS-1:0] row_one_col_two_im;
    logic signed [VALUE_BITS-1:0] row_two_col_zero_re;
    logic signed [VALUE_BITS-1:0] row_two_col_zero_im;
    logic signed [VALUE_BITS-1:0] row_two_col_one_re;
    logic signed [VALUE_BITS-1:0] row_two_col_one_im;
    logic signed [VALUE_BITS-1:0] row_two_col_two_re;
    logic signed [VALUE_BITS-1:0] row_two_col_two_im;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] element_value;
    logic [POS_W-1:0]             element_position;
    logic                         last_of_matrix;
  } out_item_t;

  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_en;
    logic fin_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic             neg;
  } term_t;

  // Operand indices and sign of each product term of each third-row value
  function automatic term_t term_sel(input logic [LANE_W-1:0] lane,
                                     input logic [TERM_W-1:0] term);
    term_t t;
    t = '0;
    case ({lane, term})
      {3'd0, 2'd0}: t = '{4'd2, 4'd10, 1'b0};
      {3'd0, 2'd1}: t = '{4'd4, 4'd8,  1'b1};
      {3'd0, 2'd2}: t = '{4'd3, 4'd11, 1'b1};
      {3'd0, 2'd3}: t = '{4'd5, 4'd9,  1'b0};
      {3'd1, 2'd0}: t = '{4'd4, 4'd9,  1'b0};
      {3'd1, 2'd1}: t = '{4'd2, 4'd11, 1'b1};
      {3'd1, 2'd2}: t = '{4'd5, 4'd8,  1'b0};
      {3'd1, 2'd3}: t = '{4'd3, 4'd10, 1'b1};
      {3'd2, 2'd0}: t = '{4'd4, 4'd6,  1'b0};
      {3'd2, 2'd1}: t = '{4'd0, 4'd10, 1'b1};
      {3'd2, 2'd2}: t = '{4'd5, 4'd7,  1'b1};
      {3'd2, 2'd3}: t = '{4'd1, 4'd11, 1'b0};
      {3'd3, 2'd0}: t = '{4'd0, 4'd11, 1'b0};
      {3'd3, 2'd1}: t = '{4'd4, 4'd7,  1'b1};
      {3'd3, 2'd2}: t = '{4'd1, 4'd10, 1'b0};
      {3'd3, 2'd3}: t = '{4'd5, 4'd6,  1'b1};
      {3'd4, 2'd0}: t = '{4'd0, 4'd8,  1'b0};
      {3'd4, 2'd1}: t = '{4'd2, 4'd6,  1'b1};
      {3'd4, 2'd2}: t = '{4'd1, 4'd9,  1'b1};
      {3'd4, 2'd3}: t = '{4'd3, 4'd7,  1'b0};
      {3'd5, 2'd0}: t = '{4'd2, 4'd7,  1'b0};
      {3'd5, 2'd1}: t = '{4'd0, 4'd9,  1'b1};
      {3'd5, 2'd2}: t = '{4'd3, 4'd6,  1'b0};
      {3'd5, 2'd3}: t = '{4'd1, 4'd8,  1'b1};
      default:      t = '0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/su3r_lane.sv @@
// One third-row lane: serial multiply-accumulate of four signed products,
// then rounding and saturation. Depends on su3r_pkg.
`default_nettype none

module su3r_lane (
  input  wire logic                                   clk,
  input  wire logic signed [su3r_pkg::VALUE_BITS-1:0] op_a,
  input  wire logic signed [su3r_pkg::VALUE_BITS-1:0] op_b,
  input  wire logic                                   op_neg,
  input  wire su3r_pkg::lane_ctrl_t                   ctrl,
  output logic        [su3r_pkg::VALUE_BITS-1:0]      result
);

  logic signed [su3r_pkg::PROD_W-1:0]     prod_r, prod_nxt;
  logic                                   neg_r;
  logic signed [su3r_pkg::ACC_W-1:0]      acc_r, acc_nxt;
  logic        [su3r_pkg::VALUE_BITS-1:0] result_r, result_nxt;

  logic signed [su3r_pkg::ACC_W-1:0]      term_ext;
  logic signed [su3r_pkg::ACC_W-1:0]      rounded;
  logic signed [su3r_pkg::ACC_W-1:0]      shifted;
  logic [su3r_pkg::ACC_W-su3r_pkg::VALUE_BITS:0] upper;

  // multiply one term pair
  assign prod_nxt = op_a * op_b;

  // extend the registered product and apply the term sign
  always_comb begin
    term_ext = {{2{prod_r[su3r_pkg::PROD_W-1]}}, prod_r};
    if (neg_r) begin
      term_ext = -term_ext;
    end
    acc_nxt = ctrl.acc_load ? term_ext : acc_r + term_ext;
  end

  // round once, then saturate to the value range
  always_comb begin
    rounded = acc_r + su3r_pkg::ROUND_HALF;
    shifted = rounded >>> su3r_pkg::FRAC_BITS;
    upper   = shifted[su3r_pkg::ACC_W-1:su3r_pkg::VALUE_BITS-1];
    if ((&upper) || !(|upper)) begin
      result_nxt = shifted[su3r_pkg::VALUE_BITS-1:0];
    end else if (shifted[su3r_pkg::ACC_W-1]) begin
      result_nxt = {1'b1, {(su3r_pkg::VALUE_BITS-1){1'b0}}};
    end else begin
      result_nxt = {1'b0, {(su3r_pkg::VALUE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
      neg_r  <= op_neg;
    end
    if (ctrl.acc_load || ctrl.acc_en) begin
      acc_r <= acc_nxt;
    end
    if (ctrl.fin_en) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

`default_nettype wire

@@ hw/rtl/su3r_out_seq.sv @@
// Output merge and sequencer: gathers the twelve passed values and the six lane results
// into one bank and shifts them out one item per cycle unless stalled. Depends on su3r_pkg.
`default_nettype none

module su3r_out_seq (
  input  wire logic                                                   clk,
  input  wire logic                                                   rst_n,
  input  wire logic                                                   load,
  input  wire su3r_pkg::in_item_t                                     pass_item,
  input  wire logic [su3r_pkg::LANE_COUNT-1:0][su3r_pkg::VALUE_BITS-1:0] lane_res,
  input  wire logic                                                   out_stall,
  output logic                                                        out_valid,
  output su3r_pkg::out_item_t                                         out_item,
  output logic                                                        free
);

  logic [su3r_pkg::PASS_COUNT-1:0][su3r_pkg::VALUE_BITS-1:0] pass_vec;
  logic [su3r_pkg::VALUE_BITS-1:0] bank_r [su3r_pkg::MATRIX_COUNT];
  logic [su3r_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic                            valid_r, valid_nxt;
  logic                            take;
  logic                            at_last;

  // first field sits at the top of the packed struct
  assign pass_vec = pass_item;

  assign take    = valid_r && !out_stall;
  assign at_last = (pos_r == su3r_pkg::POS_LAST);
  assign free    = !valid_r || (take && at_last);

  // advance position, drop valid after the last item
  always_comb begin
    valid_nxt = valid_r;
    pos_nxt   = pos_r;
    if (load) begin
      valid_nxt = 1'b1;
      pos_nxt   = '0;
    end else if (take) begin
      if (at_last) begin
        valid_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // load the whole matrix, or shift by one on each taken item
  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < su3r_pkg::PASS_COUNT; k++) begin
        bank_r[k] <= pass_vec[su3r_pkg::PASS_COUNT-1-k];
      end
      for (int k = 0; k < su3r_pkg::LANE_COUNT; k++) begin
        bank_r[su3r_pkg::PASS_COUNT+k] <= lane_res[k];
      end
    end else if (take) begin
      for (int k = 0; k < su3r_pkg::MATRIX_COUNT-1; k++) begin
        bank_r[k] <= bank_r[k+1];
      end
    end
  end

  assign out_valid                 = valid_r;
  assign out_item.element_value    = $signed(bank_r[0]);
  assign out_item.element_position = pos_r;
  assign out_item.last_of_matrix   = at_last;

endmodule

`default_nettype wire

@@ hw/rtl/su3_third_row_reconstruct_top.sv @@
// An accepted item passes the held-item, product, accumulator, lane result and output
// bank registers before its first result; the 18 results then follow one per cycle when
// the output is not stalled. Throughput is set by the one-item-per-cycle output channel;
// each of the six lanes runs its four products through one multiplier, under cover of
// the previous matrix being shifted out. Reset clears the valid flags and output position
// and sets the step counter to its done step; the matrix and lane registers are not reset.
`default_nettype none

module su3_third_row_reconstruct_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire su3r_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output su3r_pkg::out_item_t      out_item
);

  su3r_pkg::in_item_t           item_r;
  logic                         a_valid_r, a_valid_nxt;
  logic [su3r_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                         in_take;
  logic                         a_done;
  logic                         seq_free;
  logic                         transfer;
  su3r_pkg::lane_ctrl_t         ctrl;

  logic [su3r_pkg::PASS_COUNT-1:0][su3r_pkg::VALUE_BITS-1:0] item_vec;
  logic [su3r_pkg::VALUE_BITS-1:0] vals [su3r_pkg::PASS_COUNT];
  logic [su3r_pkg::LANE_COUNT-1:0][su3r_pkg::VALUE_BITS-1:0] lane_res;

  // handshake and hand-over to the output sequencer
  assign a_done   = (step_r == su3r_pkg::STEP_DONE);
  assign transfer = a_valid_r && a_done && seq_free;
  assign in_stall = a_valid_r && !(a_done && seq_free);
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    a_valid_nxt = a_valid_r;
    step_nxt    = step_r;
    if (in_take) begin
      a_valid_nxt = 1'b1;
      step_nxt    = '0;
    end else begin
      if (transfer) begin
        a_valid_nxt = 1'b0;
      end
      if (a_valid_r && !a_done) begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      step_r    <= su3r_pkg::STEP_DONE;
    end else begin
      a_valid_r <= a_valid_nxt;
      step_r    <= step_nxt;
    end
  end

  // hold the accepted matrix while the lanes work on it
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_item;
    end
  end

  // lane control from the step counter
  always_comb begin
    ctrl.mul_en   = a_valid_r && (step_r <= su3r_pkg::STEP_LAST_MUL);
    ctrl.acc_load = a_valid_r && (step_r == su3r_pkg::STEP_ACC_LOAD);
    ctrl.acc_en   = a_valid_r && (step_r > su3r_pkg::STEP_ACC_LOAD) &&
                    (step_r <= su3r_pkg::STEP_LAST_ACC);
    ctrl.fin_en   = a_valid_r && (step_r == su3r_pkg::STEP_FIN);
  end

  // unpack the held matrix into values indexed in field order
  assign item_vec = item_r;

  for (genvar k = 0; k < su3r_pkg::PASS_COUNT; k++) begin : g_vals
    assign vals[k] = item_vec[su3r_pkg::PASS_COUNT-1-k];
  end

  // six lanes, one per third-row value
  for (genvar g = 0; g < su3r_pkg::LANE_COUNT; g++) begin : g_lane
    su3r_pkg::term_t sel;

    assign sel = su3r_pkg::term_sel(su3r_pkg::LANE_W'(g),
                                    step_r[su3r_pkg::TERM_W-1:0]);

    su3r_lane u_lane (
      .clk    (clk),
      .op_a   ($signed(vals[sel.a])),
      .op_b   ($signed(vals[sel.b])),
      .op_neg (sel.neg),
      .ctrl   (ctrl),
      .result (lane_res[g])
    );
  end

  su3r_out_seq u_out_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (transfer),
    .pass_item (item_r),
    .lane_res  (lane_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .free      (seq_free)
  );

  // positions step by one within a matrix
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_item.last_of_matrix) |=>
      (out_valid && out_item.element_position ==
        $past(out_item.element_position) + 1'b1))
    else $error("result position did not advance by one");

  // a new matrix starts at position zero
  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    transfer |=> (out_valid && out_item.element_position == '0))
    else $error("loaded matrix does not start at position zero");

  // no hand-over while a matrix is still being shifted out
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last_of_matrix) |-> !transfer)
    else $error("matrix handed over before previous one finished");

  // the lanes only finish a value on a held item
  a_fin_held: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.fin_en |=> (a_valid_r && a_done))
    else $error("lane result finished without a held item");

endmodule

`default_nettype wire
